### sv/fte_pkg.sv
// Shared types, constants and entry pack/unpack helpers for the FAT12 table engine.
`default_nettype none

package fte_pkg;

    localparam int BYTE_W  = 8;
    localparam int ENTRY_W = 12;
    // byte offset of an entry: cluster + cluster/2, cluster up to 4095
    localparam int OFF_W   = 13;

    localparam logic [ENTRY_W-1:0] ENTRY_MAX  = 12'hFFF;
    localparam logic [ENTRY_W-1:0] FREE_ENTRY = 12'h000;

    localparam logic [BYTE_W-1:0] LO_NIBBLE = 8'h0F;
    localparam logic [BYTE_W-1:0] HI_NIBBLE = 8'hF0;
    localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hFF;

    // operation codes
    typedef enum logic [2:0] {
        F_LOAD  = 3'd0,
        F_READ  = 3'd1,
        F_GET   = 3'd2,
        F_SET   = 3'd3,
        F_ALLOC = 3'd4,
        F_FREE  = 3'd5,
        F_COUNT = 3'd6
    } t_func;

    // configuration register indexes
    localparam logic [1:0] CFG_TOTAL = 2'd0;
    localparam logic [1:0] CFG_SIZE  = 2'd1;
    localparam logic [1:0] CFG_END   = 2'd2;

    // Extract a 12-bit entry from its two bytes; b0 is the byte at the offset.
    function automatic logic [ENTRY_W-1:0] fte_unpack(
        input logic              odd,
        input logic [BYTE_W-1:0] b0,
        input logic [BYTE_W-1:0] b1
    );
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
        if (odd) begin
            lo = (b0 & HI_NIBBLE) >> 4;
            return {b1, lo[3:0]};
        end else begin
            hi = b1 & LO_NIBBLE;
            return {hi[3:0], b0};
        end
    endfunction

    // Merge a 12-bit entry into its two bytes; returns {new b1, new b0}.
    function automatic logic [2*BYTE_W-1:0] fte_pack(
        input logic               odd,
        input logic [BYTE_W-1:0]  b0,
        input logic [BYTE_W-1:0]  b1,
        input logic [ENTRY_W-1:0] v
    );
        logic [BYTE_W-1:0] nb0;
        logic [BYTE_W-1:0] nb1;
        if (odd) begin
            nb0 = (b0 & LO_NIBBLE) | {v[3:0], 4'h0};
            nb1 = v[11:4] & FULL_BYTE;
        end else begin
            nb0 = v[7:0] & FULL_BYTE;
            nb1 = (b1 & HI_NIBBLE) | {4'h0, v[11:8]};
        end
        return {nb1, nb0};
    endfunction

endpackage

`default_nettype wire

### sv/fte_ram.sv
// Byte-wide simple dual-port RAM bank with a registered read port.
`default_nettype none

module fte_ram
    import fte_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    // write one byte, and read one byte into the registered read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/fat12_table_engine.sv
// FAT12 allocation table engine: byte-packed 12-bit entries in two RAM banks.
`default_nettype none

// The table is held as even and odd byte banks, so both bytes of an entry are
// read, and written back, in the same cycle. An operation beat is taken when
// start is high and busy is low. Its single result appears on the result
// ports for one cycle with o_result_valid and must be taken then. Load byte and
// unused codes give their result on the cycle after the beat. So do allocate
// and count with no clusters, and a free whose start cluster ends the walk at
// once. Read byte, get entry and set entry pass through the check and read
// states before the result. Allocate and count visit each cluster scanned,
// and free chain each link, in turn. The banks have a registered read port:
// each entry passes a check state that issues the read and an evaluate state
// that uses the data and writes back. One operation runs at a time.
// Table contents are undefined until loaded; there is no clearing pass.
// TABLE_BYTES must be even; the engine does not check it.

module fat12_table_engine
    import fte_pkg::*;
#(
    parameter int TABLE_BYTES = 2048
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          i_func,
    input  logic [10:0]         i_byte_address,
    input  logic [BYTE_W-1:0]   i_byte_data,
    input  logic [ENTRY_W-1:0]  i_cluster,
    input  logic [ENTRY_W-1:0]  i_entry_value,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [ENTRY_W-1:0]  i_cfg_data,
    output logic                o_result_valid,
    output logic [ENTRY_W-1:0]  o_result_value,
    output logic                o_out_of_range
);

    localparam int BANK_DEPTH = TABLE_BYTES / 2;
    localparam int BW         = $clog2(BANK_DEPTH);
    localparam logic [OFF_W:0] TB = (OFF_W + 1)'(TABLE_BYTES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHK,
        S_RD
    } t_state;

    t_state               r_state;
    logic [2:0]           r_func;
    logic [10:0]          r_addr;
    logic [OFF_W-1:0]     r_cur;
    logic [ENTRY_W-1:0]   r_val;
    logic [ENTRY_W-1:0]   r_cnt;
    logic                 r_fits;
    logic                 r_odd;
    logic [BW-1:0]        r_ea;
    logic [BW-1:0]        r_oa;
    logic [ENTRY_W-1:0]   r_total;
    logic [ENTRY_W-1:0]   r_size;
    logic [ENTRY_W-1:0]   r_end;
    logic                 r_valid;
    logic [ENTRY_W-1:0]   r_res;
    logic                 r_oor;

    logic                 accept;
    logic [OFF_W:0]       size_use;
    logic [OFF_W-1:0]     chk_off;
    logic [OFF_W:0]       chk_off_w;
    logic [OFF_W:0]       chk_hi;
    logic                 chk_fits;
    logic [BW-1:0]        chk_ea;
    logic [BW-1:0]        chk_oa;
    logic [OFF_W-1:0]     in_addr_w;
    logic                 in_addr_ok;
    logic [BYTE_W-1:0]    even_q;
    logic [BYTE_W-1:0]    odd_q;
    logic [BYTE_W-1:0]    rd_b0;
    logic [BYTE_W-1:0]    rd_b1;
    logic [ENTRY_W-1:0]   rd_entry;
    logic                 rd_zero;
    logic [2*BYTE_W-1:0]  rd_pack;
    logic [OFF_W-1:0]     n_cur;
    logic                 scan_more;
    logic [ENTRY_W-1:0]   n_cnt;
    logic [ENTRY_W-1:0]   sat_cnt;
    logic                 start_walk;
    logic                 next_walk;
    logic                 idle_done;
    logic                 rd_done;
    logic                 n_valid;
    logic                 ld_we;
    logic                 we_e;
    logic                 we_o;
    logic [BW-1:0]        wa_e;
    logic [BW-1:0]        wa_o;
    logic [BYTE_W-1:0]    wd_e;
    logic [BYTE_W-1:0]    wd_o;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // effective table size: the smaller of the register and the storage
    assign size_use = ({2'b00, r_size} < TB) ? {2'b00, r_size} : TB;

    // byte offset of the access and its bank addresses
    assign chk_off   = (r_func == F_READ) ? OFF_W'(r_addr) : r_cur + {1'b0, r_cur[OFF_W-1:1]};
    assign chk_off_w = {1'b0, chk_off};
    assign chk_hi    = chk_off_w + (OFF_W + 1)'(1);
    assign chk_fits  = (r_func == F_READ) ? (chk_off_w < TB) : (chk_hi < size_use);
    assign chk_ea    = chk_hi[BW:1];
    assign chk_oa    = chk_off[BW:1];

    // raw byte load straight from the input beat
    assign in_addr_w  = OFF_W'(i_byte_address);
    assign in_addr_ok = ({1'b0, in_addr_w} < TB);
    assign ld_we      = accept && (i_func == F_LOAD) && in_addr_ok;

    // reorder bank data into low and high byte of the entry
    assign rd_b0    = r_odd ? odd_q : even_q;
    assign rd_b1    = r_odd ? even_q : odd_q;
    assign rd_entry = r_fits ? fte_unpack(r_cur[0], rd_b0, rd_b1) : r_end;
    assign rd_zero  = (rd_entry == FREE_ENTRY);
    assign rd_pack  = fte_pack(r_cur[0], rd_b0, rd_b1,
                               (r_func == F_SET) ? r_val : FREE_ENTRY);

    // scan and walk bookkeeping
    assign n_cur      = r_cur + OFF_W'(1);
    assign scan_more  = ({1'b0, n_cur} < ({2'b00, r_total} + (OFF_W + 1)'(2)));
    assign n_cnt      = r_cnt + ENTRY_W'(rd_zero);
    assign sat_cnt    = (r_cnt == ENTRY_MAX) ? r_cnt : r_cnt + ENTRY_W'(1);
    assign start_walk = (i_cluster >= ENTRY_W'(2)) && (i_cluster < r_end);
    assign next_walk  = (rd_entry >= ENTRY_W'(2)) && (rd_entry < r_end);

    // operations that finish on the beat itself, without a table access
    assign idle_done = !(i_func inside {F_READ, F_GET, F_SET})
                    && !((i_func inside {F_ALLOC, F_COUNT}) && (r_total != '0))
                    && !((i_func == F_FREE) && start_walk);

    // operations that finish on the evaluate cycle
    always_comb begin
        case (r_func)
            F_ALLOC: rd_done = rd_zero || !scan_more;
            F_COUNT: rd_done = !scan_more;
            F_FREE:  rd_done = !r_fits || !next_walk;
            default: rd_done = 1'b1;
        endcase
    end

    assign n_valid = (accept && idle_done) || ((r_state == S_RD) && rd_done);

    // bank write ports: raw load while idle, entry write-back on evaluate
    always_comb begin
        we_e = 1'b0;
        we_o = 1'b0;
        wa_e = r_ea;
        wa_o = r_oa;
        wd_e = r_odd ? rd_pack[2*BYTE_W-1:BYTE_W] : rd_pack[BYTE_W-1:0];
        wd_o = r_odd ? rd_pack[BYTE_W-1:0] : rd_pack[2*BYTE_W-1:BYTE_W];
        if (r_state == S_IDLE) begin
            we_e = ld_we && !in_addr_w[0];
            we_o = ld_we && in_addr_w[0];
            wa_e = in_addr_w[BW:1];
            wa_o = in_addr_w[BW:1];
            wd_e = i_byte_data;
            wd_o = i_byte_data;
        end else if (r_state == S_RD) begin
            we_e = r_fits && ((r_func == F_SET) || (r_func == F_FREE));
            we_o = we_e;
        end
    end

    fte_ram #(
        .DEPTH (BANK_DEPTH),
        .AW    (BW)
    ) u_even (
        .i_clk   (i_clk),
        .i_we    (we_e),
        .i_waddr (wa_e),
        .i_wdata (wd_e),
        .i_raddr (chk_ea),
        .o_rdata (even_q)
    );

    fte_ram #(
        .DEPTH (BANK_DEPTH),
        .AW    (BW)
    ) u_odd (
        .i_clk   (i_clk),
        .i_we    (we_o),
        .i_waddr (wa_o),
        .i_wdata (wd_o),
        .i_raddr (chk_oa),
        .o_rdata (odd_q)
    );

    // sequencer, configuration registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_total <= 12'd0;
            r_size  <= 12'd1536;
            r_end   <= 12'd4095;
        end else begin
            r_valid <= n_valid;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TOTAL: r_total <= i_cfg_data;
                    CFG_SIZE:  r_size  <= i_cfg_data;
                    CFG_END:   r_end   <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_func <= i_func;
                        r_addr <= i_byte_address;
                        r_cur  <= (i_func inside {F_ALLOC, F_COUNT}) ? OFF_W'(2)
                                                                    : {1'b0, i_cluster};
                        r_val  <= i_entry_value;
                        r_cnt  <= '0;
                        r_res  <= '0;
                        r_oor  <= 1'b0;
                        case (i_func)
                            F_READ, F_GET, F_SET: begin
                                r_state <= S_CHK;
                            end
                            F_ALLOC, F_COUNT: begin
                                if (r_total != '0) begin
                                    r_state <= S_CHK;
                                end
                            end
                            F_FREE: begin
                                if (start_walk) begin
                                    r_state <= S_CHK;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                S_CHK: begin
                    r_fits  <= chk_fits;
                    r_odd   <= chk_off[0];
                    r_ea    <= chk_ea;
                    r_oa    <= chk_oa;
                    r_state <= S_RD;
                end

                S_RD: begin
                    case (r_func)
                        F_READ: begin
                            r_res   <= r_fits ? {4'h0, rd_b0} : '0;
                            r_state <= S_IDLE;
                        end
                        F_GET: begin
                            r_res   <= rd_entry;
                            r_oor   <= !r_fits;
                            r_state <= S_IDLE;
                        end
                        F_SET: begin
                            r_oor   <= !r_fits;
                            r_state <= S_IDLE;
                        end
                        F_ALLOC: begin
                            if (rd_zero) begin
                                r_res   <= r_cur[ENTRY_W-1:0];
                                r_state <= S_IDLE;
                            end else if (scan_more) begin
                                r_cur   <= n_cur;
                                r_state <= S_CHK;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                        F_COUNT: begin
                            r_cnt <= n_cnt;
                            if (scan_more) begin
                                r_cur   <= n_cur;
                                r_state <= S_CHK;
                            end else begin
                                r_res   <= n_cnt;
                                r_state <= S_IDLE;
                            end
                        end
                        F_FREE: begin
                            if (!r_fits) begin
                                r_res   <= r_cnt;
                                r_oor   <= 1'b1;
                                r_state <= S_IDLE;
                            end else begin
                                r_cnt <= sat_cnt;
                                if (next_walk) begin
                                    r_cur   <= {1'b0, rd_entry};
                                    r_state <= S_CHK;
                                end else begin
                                    r_res   <= sat_cnt;
                                    r_state <= S_IDLE;
                                end
                            end
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result_valid = r_valid;
    assign o_result_value = r_res;
    assign o_out_of_range = r_oor;

`ifndef SYNTHESIS
    // a result comes from an immediate beat or from the evaluate cycle
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && $past(i_rst_n)) |->
            ($past(start && !busy) || $past(r_state == S_RD)))
        else $error("result strobe without a finishing operation");

    // a finished operation always leaves the engine free for the next beat
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    // write-back only touches entries inside the table in use
    a_write_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RD) && (we_e || we_o)) |-> r_fits)
        else $error("entry write-back outside the table");

    // the running count never drops while an operation is in flight
    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(r_state != S_IDLE)) |-> (r_cnt >= $past(r_cnt)))
        else $error("running count decreased");
`endif

endmodule

`default_nettype wire
